[rtl/olmrs_pkg.sv]
// olmrs_pkg: shared codes, widths and the controller-to-datapath command struct
// used by the ordered list controller, datapath and top level; no dependencies
package olmrs_pkg;

	localparam int CMD_W = 3;
	localparam int ID_W  = 9;
	localparam int OFF_W = 2;
	localparam int ST_W  = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TOP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BOTTOM = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RANK   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SELECT = 3'd5;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_ABSENT   = 2'd1;
	localparam logic [ST_W-1:0] ST_PAST_END = 2'd2;
	localparam logic [ST_W-1:0] ST_LOAD_REJ = 2'd3;

	// swap offset codes
	localparam logic signed [OFF_W-1:0] OFF_NONE = 2'sd0;
	localparam logic signed [OFF_W-1:0] OFF_DOWN = 2'sd1;
	localparam logic signed [OFF_W-1:0] OFF_UP   = -2'sd1;

	typedef struct packed {
		logic capture; // latch the incoming beat and register the cell matches
		logic apply;   // encode, update the cells and load the result register
	} olmrs_ctl_t;

endpackage

[rtl/olmrs_ctrl.sv]
// olmrs_ctrl: two-state sequencer for the ordered list, owns the handshakes
// and the result valid flag; depends on olmrs_pkg
module olmrs_ctrl
	import olmrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output olmrs_ctl_t ctl
);

	typedef enum logic {
		S_IDLE,
		S_APPLY
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign ctl.capture = in_valid && in_ready;
	assign ctl.apply   = (state_q == S_APPLY) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.capture) state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (ctl.apply) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (ctl.apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/olmrs_dp.sv]
// olmrs_dp: row of list cells with per-cell match, one-hot encode, shift and
// swap update, and the result register; depends on olmrs_pkg
module olmrs_dp
	import olmrs_pkg::*;
#(
	parameter int MAX_ITEMS = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  olmrs_ctl_t              ctl,
	input  logic [CMD_W-1:0]        cmd,
	input  logic [ID_W-1:0]         target,
	input  logic signed [OFF_W-1:0] offset,
	output logic [ST_W-1:0]         status,
	output logic [ID_W-1:0]         value
);

	localparam int PW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [ID_W-1:0]         cell_q [MAX_ITEMS];
	logic [CW-1:0]           count_q;
	logic [CMD_W-1:0]        cmd_q;
	logic [ID_W-1:0]         target_q;
	logic signed [OFF_W-1:0] offset_q;
	logic [MAX_ITEMS-1:0]    hit_s1;
	logic [MAX_ITEMS-1:0]    hit_d;
	logic [ST_W-1:0]         status_q;
	logic [ID_W-1:0]         value_q;

	logic [PW-1:0]   pos;
	logic [ID_W-1:0] id_sel;
	logic            found;
	logic signed [PW+1:0] q_pos;
	logic            past;
	logic            load_ok;
	logic            swap_ok;
	logic [ST_W-1:0] st_d;
	logic [ID_W-1:0] val_d;

	assign status = status_q;
	assign value  = value_q;

	// per-cell match against the incoming beat
	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (cmd == CMD_SELECT) begin
				hit_d[i] = (i + 1 == int'(target)) && (i < int'(count_q));
			end else begin
				hit_d[i] = (cell_q[i] == target) && (target != '0) && (i < int'(count_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= cmd;
			target_q <= target;
			offset_q <= offset;
			hit_s1   <= hit_d;
		end
	end

	// one-hot encode of the matching cell, position and contents
	always_comb begin
		pos    = '0;
		id_sel = '0;
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (hit_s1[i]) begin
				pos    = pos | PW'(i);
				id_sel = id_sel | cell_q[i];
			end
		end
	end

	assign found   = |hit_s1;
	assign q_pos   = signed'({2'b00, pos}) + (PW+2)'(offset_q);
	assign past    = q_pos[PW+1] || (q_pos[PW:0] >= (PW+1)'(count_q));
	assign swap_ok = found && (offset_q != OFF_NONE) && !past;
	assign load_ok = (target_q != '0) && (int'(target_q) <= MAX_ITEMS)
		&& (int'(count_q) < MAX_ITEMS) && !found;

	always_comb begin
		st_d  = ST_OK;
		val_d = '0;
		case (cmd_q)
			CMD_LOAD: begin
				if (!load_ok) st_d = ST_LOAD_REJ;
			end
			CMD_TOP, CMD_BOTTOM: begin
				if (!found) st_d = ST_ABSENT;
			end
			CMD_SWAP: begin
				if (!found) begin
					st_d = ST_ABSENT;
				end else if ((offset_q != OFF_NONE) && past) begin
					st_d = ST_PAST_END;
				end
			end
			CMD_RANK: begin
				if (!found) begin
					st_d = ST_ABSENT;
				end else begin
					val_d = ID_W'(pos);
				end
			end
			CMD_SELECT: begin
				if (!found) begin
					st_d = ST_ABSENT;
				end else begin
					val_d = id_sel;
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			status_q <= st_d;
			value_q  <= val_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.apply && (cmd_q == CMD_LOAD) && load_ok) begin
			count_q <= count_q + 1'b1;
		end
	end

	// cell update, each cell reads only itself and its fixed neighbors
	for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
		localparam int UP1 = (g > 0) ? g - 1 : 0;
		localparam int UP2 = (g > 1) ? g - 2 : 0;
		localparam int DN1 = (g < MAX_ITEMS - 1) ? g + 1 : g;

		logic [ID_W-1:0] nxt;
		logic            we;

		always_comb begin
			we  = 1'b0;
			nxt = cell_q[g];
			case (cmd_q)
				CMD_LOAD: begin
					if (load_ok && (g == int'(count_q))) begin
						we  = 1'b1;
						nxt = target_q;
					end
				end
				CMD_TOP: begin
					if (found && (g == 0)) begin
						we  = 1'b1;
						nxt = target_q;
					end else if (found && (g <= int'(pos))) begin
						we  = 1'b1;
						nxt = cell_q[UP1];
					end
				end
				CMD_BOTTOM: begin
					if (found && (g == int'(count_q) - 1)) begin
						we  = 1'b1;
						nxt = target_q;
					end else if (found && (g >= int'(pos)) && (g < int'(count_q) - 1)) begin
						we  = 1'b1;
						nxt = cell_q[DN1];
					end
				end
				CMD_SWAP: begin
					if (swap_ok && hit_s1[g]) begin
						we = 1'b1;
						if (offset_q == OFF_DOWN) begin
							nxt = cell_q[DN1];
						end else if (offset_q == OFF_UP) begin
							nxt = cell_q[UP1];
						end else begin
							nxt = cell_q[UP2];
						end
					end else if (swap_ok && (g == int'(q_pos[PW:0]))) begin
						we  = 1'b1;
						nxt = target_q;
					end
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end

		always_ff @(posedge clk) begin
			if (ctl.apply && we) cell_q[g] <= nxt;
		end
	end

endmodule

[rtl/ordered_list_move_rank_select_top.sv]
// ordered_list_move_rank_select_top: ordered id list with move to top/bottom,
// neighbor swap, rank and select; uses olmrs_pkg, olmrs_ctrl, olmrs_dp
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | sink      | in_valid / in_ready  | cmd[2:0] target[8:0] offset[1:0]
//   out     | source    | out_valid / out_ready| status[1:0] value[8:0]
//
// each command has an accept edge and an update edge: the accept edge compares the
// target against all list cells at once, the update edge encodes the match, shifts
// or swaps the cells and loads the result register; one beat in, one beat out
// a result waiting in the output register does not block the next accept;
// only the update edge waits until that register is free
// asynchronous reset empties the list (count zero) and idles both channels
module ordered_list_move_rank_select_top
	import olmrs_pkg::*;
#(
	parameter int MAX_ITEMS = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CMD_W-1:0]        cmd,
	input  logic [ID_W-1:0]         target,
	input  logic signed [OFF_W-1:0] offset,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ST_W-1:0]         status,
	output logic [ID_W-1:0]         value
);

	olmrs_ctl_t ctl;

	// sequencer: handshakes and the capture/apply commands
	olmrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// list cells, match/encode logic and result register
	olmrs_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.target (target),
		.offset (offset),
		.status (status),
		.value  (value)
	);

	// an accepted beat blocks the input for the update cycle
	a_busy_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> !in_ready)
	else $error("input ready while a command is in flight");

	// the update always leaves a result in the output register
	a_result_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.apply |=> out_valid)
	else $error("update without a result beat");

	// a new result only ever comes from an update
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.apply))
	else $error("result beat without an update");

	// update never happens while idle for input
	a_apply_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.apply |-> !in_ready)
	else $error("update while the input side is idle");

endmodule

[bench/testbench.sv]
// testbench: self-checking bench for ordered_list_move_rank_select_top
// needs olmrs_pkg and the rtl of the ordered list block; the list is predicted here
`timescale 1ns / 1ps

module testbench
	import olmrs_pkg::*;
;

	localparam int LIST_DEPTH = 256;
	localparam int MAX_GAP    = 12;
	localparam int HOLD_CYCLES = 300;

	// command codes the block has no meaning for
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
	// offset pattern 2'b10: swap with the item two places above
	localparam logic signed [OFF_W-1:0] OFF_UP_TWO = 2'sb10;

	typedef struct {
		logic [CMD_W-1:0]        op;
		logic [ID_W-1:0]         id;
		logic signed [OFF_W-1:0] dir;
		int unsigned             gap;   // idle cycles before this beat is offered
		bit                      drain; // hold this beat until every result is back
	} list_cmd_t;

	typedef struct {
		logic [ST_W-1:0]  st;
		logic [ID_W-1:0]  val;
		logic [CMD_W-1:0] op;
		logic [ID_W-1:0]  id;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] cmd = CMD_LOAD;
	logic [ID_W-1:0] target = '0;
	logic signed [OFF_W-1:0] offset = OFF_NONE;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ST_W-1:0] status;
	logic [ID_W-1:0] value;

	ordered_list_move_rank_select_top #(.MAX_ITEMS(LIST_DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.target(target),
		.offset(offset),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.value(value)
	);

	// command beats waiting to be driven, and results still owed by the block
	list_cmd_t cmd_backlog[$];
	list_result_t owed_results[$];
	list_cmd_t in_flight;

	// predicted list contents, top of the list at index 0
	logic [ID_W-1:0] list_ids[LIST_DEPTH];
	int list_len = 0;

	// membership as the stimulus generator sees it; moves never change it,
	// so it can be tracked while the beats are built up front
	bit gen_loaded[1:LIST_DEPTH];
	logic [ID_W-1:0] gen_ids[$];
	bit gen_calm = 1'b0;

	int mismatches = 0;
	int beats_in = 0;
	int beats_out = 0;
	int rx_stall = 0;
	bit rx_hold = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input list_result_t want,
			input logic [ST_W-1:0] got_st, input logic [ID_W-1:0] got_val);
		$write("mismatch %0d: %s (cmd %0d target %0d)", beats_out, what, want.op, want.id);
		$display(" got status %0d value %0d, want status %0d value %0d",
			got_st, got_val, want.st, want.val);
		mismatches++;
	endtask

	// 0-based position of an id in the predicted list, -1 when absent
	function automatic int find_id(input logic [ID_W-1:0] id);
		if (id == '0)
			return -1;
		for (int i = 0; i < list_len; i++)
			if (list_ids[i] == id)
				return i;
		return -1;
	endfunction

	// runs one command against the predicted list and returns its result
	function automatic list_result_t apply_list_command(input list_cmd_t c);
		list_result_t r;
		int p;
		int q;
		logic [ID_W-1:0] moved;
		r.st = ST_OK;
		r.val = '0;
		r.op = c.op;
		r.id = c.id;
		p = find_id(c.id);
		case (c.op)
			CMD_LOAD: begin
				if (c.id == '0 || c.id > LIST_DEPTH || list_len >= LIST_DEPTH || p >= 0) begin
					r.st = ST_LOAD_REJ;
				end else begin
					list_ids[list_len] = c.id;
					list_len++;
				end
			end
			CMD_TOP, CMD_BOTTOM, CMD_SWAP, CMD_RANK: begin
				if (p < 0) begin
					r.st = ST_ABSENT;
				end else begin
					moved = list_ids[p];
					case (c.op)
						CMD_TOP: begin
							for (int i = p; i > 0; i--)
								list_ids[i] = list_ids[i-1];
							list_ids[0] = moved;
						end
						CMD_BOTTOM: begin
							for (int i = p; i + 1 < list_len; i++)
								list_ids[i] = list_ids[i+1];
							list_ids[list_len-1] = moved;
						end
						CMD_SWAP: begin
							// a zero offset still needs the item, then does nothing
							if (c.dir != OFF_NONE) begin
								q = p + int'(c.dir);
								if (q < 0 || q >= list_len) begin
									r.st = ST_PAST_END;
								end else begin
									list_ids[p] = list_ids[q];
									list_ids[q] = moved;
								end
							end
						end
						default: begin
							r.val = p[ID_W-1:0];
						end
					endcase
				end
			end
			CMD_SELECT: begin
				if (c.id == '0 || c.id > list_len)
					r.st = ST_ABSENT;
				else
					r.val = list_ids[c.id-1];
			end
			default: begin
				// spare codes leave the list alone and answer ok with zero
			end
		endcase
		return r;
	endfunction

	// queue one beat; idle gaps come in noisy stretches and calm stretches
	task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
			input logic signed [OFF_W-1:0] dir, input bit drain);
		list_cmd_t c;
		gen_calm = ((cmd_backlog.size() / 60) % 4) == 2;
		c.op = op;
		c.id = id;
		c.dir = dir;
		c.gap = gen_calm ? 0 : $urandom_range(0, MAX_GAP);
		c.drain = drain;
		cmd_backlog.push_back(c);
		if (op == CMD_LOAD && id >= 1 && id <= LIST_DEPTH && gen_ids.size() < LIST_DEPTH) begin
			if (!gen_loaded[id]) begin
				gen_loaded[id] = 1'b1;
				gen_ids.push_back(id);
			end
		end
	endtask

	function automatic logic [ID_W-1:0] pick_present();
		return gen_ids[$urandom_range(0, gen_ids.size() - 1)];
	endfunction

	// an id not in the list: mostly a free id in range, sometimes zero or too big
	function automatic logic [ID_W-1:0] pick_absent();
		logic [ID_W-1:0] id;
		if (gen_ids.size() >= LIST_DEPTH || $urandom_range(0, 3) == 0)
			return ($urandom_range(0, 1) == 0) ? '0 : ID_W'($urandom_range(LIST_DEPTH + 1, 511));
		do
			id = ID_W'($urandom_range(1, LIST_DEPTH));
		while (gen_loaded[id]);
		return id;
	endfunction

	// one random beat: a little noise, some loads, mostly commands on live ids
	task automatic queue_random(input int load_pct);
		int r;
		logic [CMD_W-1:0] op;
		logic [ID_W-1:0] id;
		logic signed [OFF_W-1:0] dir;
		r = $urandom_range(0, 99);
		dir = OFF_W'($urandom_range(0, 3));
		if (r < 8) begin
			queue_cmd(CMD_W'($urandom_range(0, 7)), ID_W'($urandom_range(0, 511)), dir, 1'b0);
		end else if (r < 8 + load_pct || gen_ids.size() == 0) begin
			if (gen_ids.size() < LIST_DEPTH && $urandom_range(0, 4) != 0)
				id = pick_absent();
			else
				id = (gen_ids.size() != 0) ? pick_present() : '0;
			queue_cmd(CMD_LOAD, id, dir, 1'b0);
		end else begin
			case ($urandom_range(0, 4))
				0: op = CMD_TOP;
				1: op = CMD_BOTTOM;
				2: op = CMD_SWAP;
				3: op = CMD_RANK;
				default: op = CMD_SELECT;
			endcase
			if (op == CMD_SELECT)
				id = ($urandom_range(0, 9) == 0) ? ID_W'(gen_ids.size() + 1)
					: ID_W'($urandom_range(1, gen_ids.size()));
			else
				id = ($urandom_range(0, 9) == 0) ? pick_absent() : pick_present();
			queue_cmd(op, id, dir, 1'b0);
		end
	endtask

	// driver: offers the backlog in order, predicting each beat as it is taken
	always @(posedge clk or negedge arst_n) begin : drive_commands
		list_cmd_t head;
		bit offering;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= CMD_LOAD;
			target <= '0;
			offset <= OFF_NONE;
		end else begin
			offering = in_valid;
			if (in_valid && in_ready) begin
				owed_results.push_back(apply_list_command(in_flight));
				beats_in++;
				offering = 1'b0;
			end
			// the next beat may follow at once, so valid is written just once below
			if (!offering && cmd_backlog.size() != 0) begin
				if (cmd_backlog[0].gap != 0) begin
					cmd_backlog[0].gap--;
				end else if (!(cmd_backlog[0].drain && owed_results.size() != 0)) begin
					head = cmd_backlog.pop_front();
					in_flight = head;
					offering = 1'b1;
					cmd <= head.op;
					target <= head.id;
					offset <= head.dir;
				end
			end
			in_valid <= offering;
		end
	end

	// monitor: takes results, compares against the oldest owed one, draws stalls
	always @(posedge clk or negedge arst_n) begin : check_results
		list_result_t want;
		bit rx_calm;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				beats_out++;
				if (owed_results.size() == 0) begin
					want = '{st: '0, val: '0, op: '0, id: '0};
					report_mismatch("result with nothing owed", want, status, value);
				end else begin
					want = owed_results.pop_front();
					if (status !== want.st)
						report_mismatch("status", want, status, value);
					if (value !== want.val)
						report_mismatch("value", want, status, value);
				end
				rx_calm = ((beats_out / 70) % 4) == 1;
				rx_stall = (rx_calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_GAP);
			end else if (rx_stall != 0) begin
				rx_stall--;
			end
			out_ready <= !rx_hold && rx_stall == 0;
		end
	end

	// long receiver hold-off in the middle of the fill phase; the sender keeps
	// offering, so the result register fills and the input has to stall
	initial begin
		while (beats_in < 500)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		// directed: rejected loads, empty-list answers, every move and the swap edges
		queue_cmd(CMD_SELECT, 9'd1, OFF_NONE, 1'b0);    // select on an empty list
		queue_cmd(CMD_RANK, 9'd5, OFF_NONE, 1'b0);      // absent item
		queue_cmd(CMD_LOAD, 9'd0, OFF_NONE, 1'b0);      // id zero rejected
		queue_cmd(CMD_LOAD, 9'd257, OFF_NONE, 1'b0);    // id past the list size
		queue_cmd(CMD_LOAD, 9'd511, OFF_UP, 1'b0);      // all target bits set
		queue_cmd(CMD_LOAD, 9'd256, OFF_NONE, 1'b0);
		queue_cmd(CMD_LOAD, 9'd1, OFF_NONE, 1'b0);
		queue_cmd(CMD_LOAD, 9'd1, OFF_NONE, 1'b0);      // duplicate rejected
		queue_cmd(CMD_LOAD, 9'd170, OFF_NONE, 1'b0);
		queue_cmd(CMD_LOAD, 9'd85, OFF_NONE, 1'b0);
		queue_cmd(CMD_LOAD, 9'd3, OFF_NONE, 1'b0);
		queue_cmd(CMD_TOP, 9'd3, OFF_NONE, 1'b0);
		queue_cmd(CMD_BOTTOM, 9'd256, OFF_NONE, 1'b0);
		queue_cmd(CMD_SWAP, 9'd170, OFF_UP, 1'b0);
		queue_cmd(CMD_SWAP, 9'd170, OFF_DOWN, 1'b0);
		queue_cmd(CMD_SWAP, 9'd85, OFF_NONE, 1'b0);     // zero offset, item present
		queue_cmd(CMD_SWAP, 9'd85, OFF_UP_TWO, 1'b0);   // two places above
		queue_cmd(CMD_SWAP, 9'd3, OFF_UP, 1'b0);        // past the top
		queue_cmd(CMD_SWAP, 9'd256, OFF_DOWN, 1'b0);    // past the bottom
		queue_cmd(CMD_SWAP, 9'd9, OFF_NONE, 1'b0);      // zero offset, item absent
		queue_cmd(CMD_RANK, 9'd256, OFF_NONE, 1'b0);
		queue_cmd(CMD_SELECT, 9'd5, OFF_NONE, 1'b0);
		queue_cmd(CMD_SELECT, 9'd6, OFF_NONE, 1'b0);    // just past the count
		queue_cmd(CMD_SELECT, 9'd0, OFF_NONE, 1'b0);
		queue_cmd(CMD_SPARE_6, 9'd511, OFF_UP_TWO, 1'b0);
		queue_cmd(CMD_SPARE_7, 9'd2, OFF_DOWN, 1'b0);
		queue_cmd(CMD_TOP, 9'd0, OFF_NONE, 1'b0);

		// random on a small, slowly growing list
		queue_cmd(CMD_RANK, pick_present(), OFF_NONE, 1'b1);
		repeat (330) begin
			if (gen_ids.size() < 40)
				queue_random(15);
			else
				queue_random(2);
		end

		// sender waits for every result, then the list is filled to the brim
		queue_cmd(CMD_SELECT, 9'd1, OFF_NONE, 1'b1);
		while (gen_ids.size() < LIST_DEPTH) begin
			queue_cmd(CMD_LOAD, pick_absent(), OFF_NONE, 1'b0);
			if ($urandom_range(0, 1) == 0)
				queue_random(0);
		end
		queue_cmd(CMD_LOAD, 9'd0, OFF_NONE, 1'b0);
		queue_cmd(CMD_LOAD, 9'd256, OFF_NONE, 1'b0);    // full list, and a duplicate
		queue_cmd(CMD_SELECT, 9'd256, OFF_NONE, 1'b0);  // last position of a full list
		queue_cmd(CMD_SELECT, 9'd257, OFF_NONE, 1'b0);

		// random on the full list
		repeat (260) queue_random(5);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		// keep the clock running so that a stray extra beat would still be seen
		repeat (16) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
